### src/lgfu_pkg.sv
// Shared types, codes and constants of the lattice game Fermi update block.
package lgfu_pkg;

	localparam int unsigned SIDE_DEFAULT = 128;
	localparam int unsigned AGE_MAX = 255;
	localparam logic [7:0] AGE_LIMIT = (AGE_MAX > 255) ? 8'd255 : 8'(AGE_MAX);

	localparam int PAY_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int EXP_IN_W = 40;
	localparam int EXP_OUT_W = 24;

	localparam logic signed [17:0] EXP_LOG2E = 18'sd94548;
	localparam int unsigned EXP_C0 = 5219;
	localparam int unsigned EXP_C1 = 14707;
	localparam int unsigned EXP_C2 = 45612;
	localparam logic [EXP_OUT_W-1:0] EXP_SAT = 24'hFFFFFF;

	localparam logic [1:0] MODE_UPDATE = 2'd0;
	localparam logic [1:0] MODE_AGE    = 2'd1;
	localparam logic [1:0] MODE_WRITE  = 2'd2;
	localparam logic [1:0] MODE_NONE   = 2'd3;

	localparam logic [1:0] DIR_RIGHT = 2'd0;
	localparam logic [1:0] DIR_LEFT  = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_UP    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_TEMPTATION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REWARD     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PUNISHMENT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SUCKER     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_SIGMA  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_NOISE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MUTATION   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_AGE_CENTRE = 3'd7;

	localparam int FETCH_W = 4;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_DIV1,
		ST_DIV2,
		ST_NB,
		ST_FETCH,
		ST_SQ,
		ST_WARG,
		ST_EXPW,
		ST_WAITW,
		ST_WMUL,
		ST_DIFF,
		ST_EXPA,
		ST_WAITA,
		ST_DECIDE,
		ST_DONE
	} lgfu_state_t;

	typedef struct packed {
		logic               latch_in;
		logic               clear;
		logic               div1;
		logic               div2;
		logic               nb;
		logic [FETCH_W-1:0] rd_idx;
		logic               cap_en;
		logic [FETCH_W-1:0] cap_idx;
		logic               sel_nb;
		logic               sq;
		logic               warg;
		logic               exp_start;
		logic               exp_arg_a;
		logic               e_latch;
		logic               wmul;
		logic               diff;
		logic               decide;
		logic               finish;
	} lgfu_cmd_t;

	typedef struct packed {
		logic       site_ok;
		logic [1:0] mode;
		logic       clear_last;
		logic       exp_done;
	} lgfu_status_t;

endpackage

### src/lgfu_ram.sv
// Generic RAM, one write port and one registered read port.
module lgfu_ram #(
	parameter int unsigned W = 9,
	parameter int unsigned D = 16384
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/lgfu_exp.sv
// Pipelined Q8.16 exponential: clamp, base-2 scaling, Horner polynomial, shift.
module lgfu_exp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [lgfu_pkg::EXP_IN_W-1:0] arg,
	output logic                                 done,
	output logic [lgfu_pkg::EXP_OUT_W-1:0]       result
);

	localparam logic signed [lgfu_pkg::EXP_IN_W-1:0] LIM = 40'sd16777216;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [25:0] a_s1;
	logic signed [27:0] y_s2;
	logic signed [11:0] q_s3, q_s4, q_s5;
	logic [15:0] f_s3, f_s4;
	logic [16:0] t1_s3, t2_s4;
	logic [17:0] p_s5;
	logic [lgfu_pkg::EXP_OUT_W-1:0] res_s6;

	logic signed [43:0] yprod;
	logic [31:0] m1, m2;
	logic [33:0] m3;
	logic [25:0] shl;
	logic [4:0] nq;

	assign yprod = a_s1 * lgfu_pkg::EXP_LOG2E;
	assign m1 = 32'(lgfu_pkg::EXP_C0) * 32'(y_s2[15:0]);
	assign m2 = 32'(t1_s3) * 32'(f_s3);
	assign m3 = 34'(t2_s4) * 34'(f_s4);
	assign shl = 26'(p_s5) << q_s5[2:0];
	assign nq = 5'(-q_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (arg > LIM) begin
			a_s1 <= 26'(LIM);
		end else if (arg < -LIM) begin
			a_s1 <= 26'(-LIM);
		end else begin
			a_s1 <= 26'(arg);
		end
		y_s2  <= 28'(yprod >>> 16);
		q_s3  <= y_s2[27:16];
		f_s3  <= y_s2[15:0];
		t1_s3 <= 17'(32'(lgfu_pkg::EXP_C1) + (m1 >> 16));
		q_s4  <= q_s3;
		f_s4  <= f_s3;
		t2_s4 <= 17'(32'(lgfu_pkg::EXP_C2) + (m2 >> 16));
		q_s5  <= q_s4;
		p_s5  <= 18'(34'd65536 + (m3 >> 16));
		if (q_s5 >= 12'sd8) begin
			res_s6 <= lgfu_pkg::EXP_SAT;
		end else if (q_s5 >= 12'sd0) begin
			res_s6 <= (shl > 26'(lgfu_pkg::EXP_SAT)) ? lgfu_pkg::EXP_SAT : shl[23:0];
		end else if (q_s5 < -12'sd17) begin
			res_s6 <= '0;
		end else begin
			res_s6 <= 24'(p_s5 >> nq);
		end
	end

	assign done = v_s6;
	assign result = res_s6;

endmodule

### src/lgfu_datapath.sv
// Datapath: registers, lattice memory, counts, payoff arithmetic and result.
module lgfu_datapath #(
	parameter int unsigned SIDE = lgfu_pkg::SIDE_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lgfu_pkg::lgfu_cmd_t               cmd,
	output lgfu_pkg::lgfu_status_t            status,
	input  logic [1:0]                        mode,
	input  logic [13:0]                       site_index,
	input  logic [1:0]                        neighbour_dir,
	input  logic [15:0]                       uniform,
	input  logic                              write_strategy,
	input  logic [7:0]                        write_age,
	input  logic                              cfg_valid,
	input  logic [lgfu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [15:0]                       cfg_data,
	output logic                              strategy_now,
	output logic [7:0]                        age_now,
	output logic                              flipped,
	output logic [14:0]                       defector_count,
	output logic [14:0]                       cooperator_count
);

	localparam int unsigned NSITES = SIDE * SIDE;
	localparam int AW  = $clog2(NSITES);
	localparam int CLW = $clog2(SIDE);
	localparam int CW  = $clog2(NSITES + 1);
	localparam int DS  = AW + CLW + 1;
	localparam int RW  = DS - CLW + 2;
	localparam longint unsigned RECIP = ((64'd1 << DS) + SIDE - 1) / SIDE;

	// configuration
	logic [15:0] temptation_q, reward_q, punishment_q, sucker_q;
	logic [15:0] inv_sigma_q, inv_noise_q, mutation_q;
	logic [7:0]  age_centre_q;

	// item
	logic [1:0]  mode_q, dir_q;
	logic [13:0] j_q;
	logic [15:0] u_q;
	logic        ws_q;
	logic [7:0]  wa_q;

	logic [AW+RW-1:0] prod_q;
	logic [CLW-1:0]   col_q, colnb_q;
	logic [AW-1:0]    nb_q, clr_q;
	logic [9:0]       sbits_q;
	logic [7:0]       age_j_q, age_nb_q;
	logic [15:0]      sq_q;
	logic [17:0]      pi_q;
	logic [31:0]      warg_q;
	logic [lgfu_pkg::EXP_OUT_W-1:0] e_q;
	logic [29:0]      wpi_j_q, wpi_nb_q;
	logic signed [lgfu_pkg::EXP_IN_W-1:0] a_q;
	logic             copy_q;
	logic [CW-1:0]    def_q, coop_q;
	logic             res_s_q, res_f_q;
	logic [7:0]       res_a_q;

	logic [AW-1:0]    ja, raddr, waddr, row_side, rbase;
	logic [CLW-1:0]   rcol;
	logic [1:0]       rdir;
	logic [8:0]       wdata, rdata;
	logic             we, site_ok;
	logic [AW+RW-DS-1:0] row;
	logic [17:0]      pi_j, pi_nb;
	logic signed [8:0] dage;
	logic [41:0]      wprod;
	logic signed [30:0] dif;
	logic signed [47:0] aprod;
	logic [24:0]      esum;
	logic [40:0]      cprod;
	logic signed [lgfu_pkg::EXP_IN_W-1:0] exp_arg;
	logic             exp_done;
	logic [lgfu_pkg::EXP_OUT_W-1:0] exp_res;
	logic             new_s, do_set, do_wr, rs_s;
	logic [7:0]       new_age, rs_a;

	function automatic logic [AW-1:0] nbr(input logic [AW-1:0] b, input logic [CLW-1:0] c,
			input logic [1:0] d);
		logic [AW:0] be;
		be = {1'b0, b};
		unique case (d)
			lgfu_pkg::DIR_RIGHT: nbr = (c == CLW'(SIDE - 1)) ? AW'(be + 1 - SIDE) : AW'(be + 1);
			lgfu_pkg::DIR_LEFT:  nbr = (c == '0) ? AW'(be + SIDE - 1) : AW'(be - 1);
			lgfu_pkg::DIR_DOWN:  nbr = (be + SIDE >= NSITES) ? AW'(be + SIDE - NSITES) :
				AW'(be + SIDE);
			lgfu_pkg::DIR_UP:    nbr = (be < SIDE) ? AW'(be + NSITES - SIDE) : AW'(be - SIDE);
		endcase
	endfunction

	function automatic logic [CLW-1:0] nbr_col(input logic [CLW-1:0] c, input logic [1:0] d);
		unique case (d)
			lgfu_pkg::DIR_RIGHT: nbr_col = (c == CLW'(SIDE - 1)) ? '0 : CLW'(c + 1'b1);
			lgfu_pkg::DIR_LEFT:  nbr_col = (c == '0) ? CLW'(SIDE - 1) : CLW'(c - 1'b1);
			lgfu_pkg::DIR_DOWN,
			lgfu_pkg::DIR_UP:    nbr_col = c;
		endcase
	endfunction

	function automatic logic [15:0] pay(input logic self_s, input logic nb_s,
			input logic [15:0] p, input logic [15:0] t, input logic [15:0] s,
			input logic [15:0] r);
		unique case ({self_s, nb_s})
			2'b00: pay = p;
			2'b01: pay = t;
			2'b10: pay = s;
			2'b11: pay = r;
		endcase
	endfunction

	assign ja = AW'(j_q);
	assign site_ok = 32'(j_q) < NSITES;
	assign row = prod_q[AW+RW-1:DS];
	assign row_side = AW'(AW'(row) * AW'(SIDE));

	// read address for fetch slot: 0 site, 1-4 its neighbours, 5 chosen neighbour, 6-9 its neighbours
	assign rbase = (cmd.rd_idx >= 4'd6) ? nb_q : ja;
	assign rcol  = (cmd.rd_idx >= 4'd6) ? colnb_q : col_q;
	assign rdir  = (cmd.rd_idx >= 4'd6) ? 2'(cmd.rd_idx - 4'd6) : 2'(cmd.rd_idx - 4'd1);

	always_comb begin
		if (cmd.rd_idx == 4'd0) begin
			raddr = ja;
		end else if (cmd.rd_idx == 4'd5) begin
			raddr = nb_q;
		end else begin
			raddr = nbr(rbase, rcol, rdir);
		end
	end

	assign pi_j = 18'(pay(sbits_q[0], sbits_q[1], punishment_q, temptation_q, sucker_q, reward_q))
		+ 18'(pay(sbits_q[0], sbits_q[2], punishment_q, temptation_q, sucker_q, reward_q))
		+ 18'(pay(sbits_q[0], sbits_q[3], punishment_q, temptation_q, sucker_q, reward_q))
		+ 18'(pay(sbits_q[0], sbits_q[4], punishment_q, temptation_q, sucker_q, reward_q));
	assign pi_nb = 18'(pay(sbits_q[5], sbits_q[6], punishment_q, temptation_q, sucker_q, reward_q))
		+ 18'(pay(sbits_q[5], sbits_q[7], punishment_q, temptation_q, sucker_q, reward_q))
		+ 18'(pay(sbits_q[5], sbits_q[8], punishment_q, temptation_q, sucker_q, reward_q))
		+ 18'(pay(sbits_q[5], sbits_q[9], punishment_q, temptation_q, sucker_q, reward_q));

	assign dage  = $signed({1'b0, cmd.sel_nb ? age_nb_q : age_j_q}) - $signed({1'b0, age_centre_q});
	assign wprod = 42'(pi_q) * 42'(e_q);
	assign dif   = $signed({1'b0, wpi_j_q}) - $signed({1'b0, wpi_nb_q});
	assign aprod = dif * $signed({1'b0, inv_noise_q});
	assign esum  = 25'(e_q) + 25'd65536;
	assign cprod = 41'(u_q) * 41'(esum);
	assign exp_arg = cmd.exp_arg_a ? a_q : -$signed({8'b0, warg_q});

	lgfu_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.exp_start),
		.arg    (exp_arg),
		.done   (exp_done),
		.result (exp_res)
	);

	// item outcome
	always_comb begin
		new_s   = sbits_q[0];
		new_age = age_j_q;
		do_set  = 1'b0;
		do_wr   = 1'b0;
		rs_s    = sbits_q[0];
		rs_a    = age_j_q;
		if (site_ok) begin
			unique case (mode_q)
				lgfu_pkg::MODE_UPDATE: begin
					new_s  = sbits_q[5];
					do_set = copy_q;
					do_wr  = copy_q;
					rs_s   = copy_q ? sbits_q[5] : sbits_q[0];
				end
				lgfu_pkg::MODE_AGE: begin
					if (u_q < mutation_q) begin
						new_age = '0;
					end else if (age_j_q < lgfu_pkg::AGE_LIMIT) begin
						new_age = age_j_q + 8'd1;
					end
					do_wr = 1'b1;
					rs_a  = new_age;
				end
				lgfu_pkg::MODE_WRITE: begin
					new_s   = ws_q;
					new_age = (wa_q > lgfu_pkg::AGE_LIMIT) ? lgfu_pkg::AGE_LIMIT : wa_q;
					do_set  = 1'b1;
					do_wr   = 1'b1;
					rs_s    = new_s;
					rs_a    = new_age;
				end
				lgfu_pkg::MODE_NONE: begin
				end
			endcase
		end else begin
			rs_s = 1'b0;
			rs_a = '0;
		end
	end

	assign we    = cmd.clear || (cmd.finish && do_wr);
	assign waddr = cmd.clear ? clr_q : ja;
	assign wdata = cmd.clear ? '0 : {new_s, new_age};

	lgfu_ram #(.W(9), .D(NSITES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temptation_q <= 16'd6144;
			reward_q     <= 16'd4096;
			punishment_q <= 16'd410;
			sucker_q     <= 16'd0;
			inv_sigma_q  <= 16'd66;
			inv_noise_q  <= 16'd2560;
			mutation_q   <= 16'd655;
			age_centre_q <= 8'd50;
			clr_q        <= '0;
			def_q        <= CW'(NSITES);
			coop_q       <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					lgfu_pkg::CFG_TEMPTATION: temptation_q <= cfg_data;
					lgfu_pkg::CFG_REWARD:     reward_q     <= cfg_data;
					lgfu_pkg::CFG_PUNISHMENT: punishment_q <= cfg_data;
					lgfu_pkg::CFG_SUCKER:     sucker_q     <= cfg_data;
					lgfu_pkg::CFG_INV_SIGMA:  inv_sigma_q  <= cfg_data;
					lgfu_pkg::CFG_INV_NOISE:  inv_noise_q  <= cfg_data;
					lgfu_pkg::CFG_MUTATION:   mutation_q   <= cfg_data;
					lgfu_pkg::CFG_AGE_CENTRE: age_centre_q <= cfg_data[7:0];
				endcase
			end
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.finish && do_set && (new_s != sbits_q[0])) begin
				if (new_s) begin
					coop_q <= coop_q + 1'b1;
					def_q  <= def_q - 1'b1;
				end else begin
					coop_q <= coop_q - 1'b1;
					def_q  <= def_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			mode_q <= mode;
			j_q    <= site_index;
			dir_q  <= neighbour_dir;
			u_q    <= uniform;
			ws_q   <= write_strategy;
			wa_q   <= write_age;
		end
		if (cmd.div1) begin
			prod_q <= (AW+RW)'(ja) * (AW+RW)'(RECIP);
		end
		if (cmd.div2) begin
			col_q <= CLW'(ja - row_side);
		end
		if (cmd.nb) begin
			nb_q    <= nbr(ja, col_q, dir_q);
			colnb_q <= nbr_col(col_q, dir_q);
		end
		if (cmd.cap_en) begin
			sbits_q[cmd.cap_idx] <= rdata[8];
			if (cmd.cap_idx == 4'd0) begin
				age_j_q <= rdata[7:0];
			end
			if (cmd.cap_idx == 4'd5) begin
				age_nb_q <= rdata[7:0];
			end
		end
		if (cmd.sq) begin
			sq_q <= 16'(dage * dage);
			pi_q <= cmd.sel_nb ? pi_nb : pi_j;
		end
		if (cmd.warg) begin
			warg_q <= 32'(sq_q) * 32'(inv_sigma_q);
		end
		if (cmd.e_latch) begin
			e_q <= exp_res;
		end
		if (cmd.wmul) begin
			if (cmd.sel_nb) begin
				wpi_nb_q <= wprod[41:12];
			end else begin
				wpi_j_q <= wprod[41:12];
			end
		end
		if (cmd.diff) begin
			a_q <= lgfu_pkg::EXP_IN_W'(aprod >>> 8);
		end
		if (cmd.decide) begin
			copy_q <= (cprod[40:32] == '0);
		end
		if (cmd.finish) begin
			res_s_q <= rs_s;
			res_a_q <= rs_a;
			res_f_q <= site_ok && (mode_q == lgfu_pkg::MODE_UPDATE) && copy_q;
		end
	end

	assign status.site_ok    = site_ok;
	assign status.mode       = mode_q;
	assign status.clear_last = (clr_q == AW'(NSITES - 1));
	assign status.exp_done   = exp_done;

	assign strategy_now     = res_s_q;
	assign age_now          = res_a_q;
	assign flipped          = res_f_q;
	assign defector_count   = 15'(def_q);
	assign cooperator_count = 15'(coop_q);

`ifndef SYNTHESIS
	a_count_total: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(def_q) + 32'(coop_q)) == NSITES)
		else $error("strategy counts do not add up to the lattice size");
`endif

endmodule

### src/lgfu_ctrl.sv
// Controller: sequences the clearing pass, lattice reads, exponentials and result.
module lgfu_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  lgfu_pkg::lgfu_status_t status,
	output lgfu_pkg::lgfu_cmd_t    cmd
);

	localparam logic [lgfu_pkg::FETCH_W-1:0] FETCH_UPDATE = 4'd10;
	localparam logic [lgfu_pkg::FETCH_W-1:0] FETCH_SINGLE = 4'd1;

	lgfu_pkg::lgfu_state_t state_q, state_d;
	logic [lgfu_pkg::FETCH_W-1:0] cnt_q, cnt_d, lim;
	logic sel_q, sel_d;
	logic out_valid_q;

	assign lim = (status.mode == lgfu_pkg::MODE_UPDATE) ? FETCH_UPDATE : FETCH_SINGLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lgfu_pkg::ST_CLEAR;
			cnt_q       <= '0;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sel_q   <= sel_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		sel_d      = sel_q;
		cmd        = '0;
		cmd.sel_nb = sel_q;
		in_ready   = 1'b0;
		unique case (state_q)
			lgfu_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_last) begin
					state_d = lgfu_pkg::ST_IDLE;
				end
			end
			lgfu_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d = lgfu_pkg::ST_CHECK;
				end
			end
			lgfu_pkg::ST_CHECK: begin
				cnt_d = '0;
				sel_d = 1'b0;
				if (!status.site_ok) begin
					state_d = lgfu_pkg::ST_DONE;
				end else if (status.mode == lgfu_pkg::MODE_UPDATE) begin
					state_d = lgfu_pkg::ST_DIV1;
				end else begin
					state_d = lgfu_pkg::ST_FETCH;
				end
			end
			lgfu_pkg::ST_DIV1: begin
				cmd.div1 = 1'b1;
				state_d = lgfu_pkg::ST_DIV2;
			end
			lgfu_pkg::ST_DIV2: begin
				cmd.div2 = 1'b1;
				state_d = lgfu_pkg::ST_NB;
			end
			lgfu_pkg::ST_NB: begin
				cmd.nb = 1'b1;
				state_d = lgfu_pkg::ST_FETCH;
			end
			lgfu_pkg::ST_FETCH: begin
				cmd.rd_idx  = cnt_q;
				cmd.cap_en  = (cnt_q != '0);
				cmd.cap_idx = cnt_q - 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == lim) begin
					state_d = (status.mode == lgfu_pkg::MODE_UPDATE) ? lgfu_pkg::ST_SQ :
						lgfu_pkg::ST_DONE;
				end
			end
			lgfu_pkg::ST_SQ: begin
				cmd.sq = 1'b1;
				state_d = lgfu_pkg::ST_WARG;
			end
			lgfu_pkg::ST_WARG: begin
				cmd.warg = 1'b1;
				state_d = lgfu_pkg::ST_EXPW;
			end
			lgfu_pkg::ST_EXPW: begin
				cmd.exp_start = 1'b1;
				state_d = lgfu_pkg::ST_WAITW;
			end
			lgfu_pkg::ST_WAITW: begin
				cmd.e_latch = status.exp_done;
				if (status.exp_done) begin
					state_d = lgfu_pkg::ST_WMUL;
				end
			end
			lgfu_pkg::ST_WMUL: begin
				cmd.wmul = 1'b1;
				if (sel_q) begin
					state_d = lgfu_pkg::ST_DIFF;
				end else begin
					sel_d = 1'b1;
					state_d = lgfu_pkg::ST_SQ;
				end
			end
			lgfu_pkg::ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d = lgfu_pkg::ST_EXPA;
			end
			lgfu_pkg::ST_EXPA: begin
				cmd.exp_start = 1'b1;
				cmd.exp_arg_a = 1'b1;
				state_d = lgfu_pkg::ST_WAITA;
			end
			lgfu_pkg::ST_WAITA: begin
				cmd.e_latch = status.exp_done;
				if (status.exp_done) begin
					state_d = lgfu_pkg::ST_DECIDE;
				end
			end
			lgfu_pkg::ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = lgfu_pkg::ST_DONE;
			end
			lgfu_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d = lgfu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lgfu_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");
	a_exp_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		status.exp_done |-> (state_q == lgfu_pkg::ST_WAITW || state_q == lgfu_pkg::ST_WAITA))
		else $error("exponential finished outside a wait state");
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == lgfu_pkg::ST_CHECK))
		else $error("accepted request not checked next cycle");
	a_fetch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lgfu_pkg::ST_FETCH) |-> (cnt_q <= FETCH_UPDATE))
		else $error("fetch counter overran");
`endif

endmodule

### src/lattice_game_fermi_update.sv
// Top level of the lattice game Fermi update block.
// Usage:
//  - Input channel (in_valid/in_ready) carries one request: mode, site_index, neighbour_dir,
//    uniform, write_strategy, write_age. Mode 0 update attempt, 1 age tick, 2 write site.
//  - Output channel (out_valid/out_ready) returns one result per request: site strategy and
//    age after the request, the copy flag and both strategy counts.
//  - Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready; write
//    only while no request is in flight.
//  - One request at a time. Before out_valid an update attempt makes ten reads through the
//    one read port of the lattice memory and three passes through the six-stage shared
//    exponential pipeline. Age ticks and writes read only the site itself, and a site off
//    the lattice reads nothing. in_ready returns the cycle after the result is loaded.
//  - A result sits in the output register until taken; the next request may be accepted
//    meanwhile, but its result waits while out_ready is low.
//  - After reset a clearing pass zeroes all SIDE*SIDE sites of the lattice (16384 by default),
//    with in_ready low; counts reset to all defectors.
module lattice_game_fermi_update #(
	parameter int unsigned SIDE = lgfu_pkg::SIDE_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     mode,
	input  logic [13:0]                    site_index,
	input  logic [1:0]                     neighbour_dir,
	input  logic [15:0]                    uniform,
	input  logic                           write_strategy,
	input  logic [7:0]                     write_age,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           strategy_now,
	output logic [7:0]                     age_now,
	output logic                           flipped,
	output logic [14:0]                    defector_count,
	output logic [14:0]                    cooperator_count,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lgfu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data
);

	lgfu_pkg::lgfu_cmd_t    cmd;
	lgfu_pkg::lgfu_status_t status;

	assign cfg_ready = 1'b1;

	lgfu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	lgfu_datapath #(.SIDE(SIDE)) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.mode             (mode),
		.site_index       (site_index),
		.neighbour_dir    (neighbour_dir),
		.uniform          (uniform),
		.write_strategy   (write_strategy),
		.write_age        (write_age),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.strategy_now     (strategy_now),
		.age_now          (age_now),
		.flipped          (flipped),
		.defector_count   (defector_count),
		.cooperator_count (cooperator_count)
	);

endmodule
